FILE: rtl/sit_pkg.sv
// Shared types, codes and default sizes for the sorted interval table.
package sit_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int TIME_WIDTH_DEF = 32;
  localparam int TAG_WIDTH_DEF  = 16;

  localparam int READ_INDEX_W = 6;
  localparam int POSITION_W   = 7;
  localparam int COUNT_W      = 7;
  localparam int STATUS_W     = 3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_PREV  = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_NEXT  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_CHECK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PLACE,
    ST_READ,
    ST_READ_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [POSITION_W-1:0] position;
    logic [COUNT_W-1:0]    count;
  } res_hdr_t;

endpackage

FILE: rtl/sit_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module sit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/sit_ctrl.sv
// Sequencer that searches, checks, shifts and reads the interval memory.
module sit_ctrl #(
  parameter int CAPACITY   = sit_pkg::CAPACITY_DEF,
  parameter int TIME_WIDTH = sit_pkg::TIME_WIDTH_DEF,
  parameter int TAG_WIDTH  = sit_pkg::TAG_WIDTH_DEF,
  localparam int AW = $clog2(CAPACITY),
  localparam int EW = 2 * TIME_WIDTH + TAG_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              opcode,
  input  logic [TIME_WIDTH-1:0]             start_time,
  input  logic [TIME_WIDTH-1:0]             end_time,
  input  logic [TAG_WIDTH-1:0]              tag,
  input  logic [sit_pkg::READ_INDEX_W-1:0]  read_index,
  output logic                              res_valid,
  input  logic                              res_ready,
  output sit_pkg::res_hdr_t                 res_hdr,
  output logic [TIME_WIDTH-1:0]             res_start,
  output logic [TIME_WIDTH-1:0]             res_end,
  output logic [TAG_WIDTH-1:0]              res_tag,
  output logic                              mem_we,
  output logic [AW-1:0]                     mem_waddr,
  output logic [EW-1:0]                     mem_wdata,
  output logic [AW-1:0]                     mem_raddr,
  input  logic [EW-1:0]                     mem_rdata
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW0   = (CNT_W > sit_pkg::READ_INDEX_W) ? CNT_W : sit_pkg::READ_INDEX_W;
  localparam int CW    = (CW0 > sit_pkg::POSITION_W) ? CW0 : sit_pkg::POSITION_W;

  sit_pkg::state_t state, state_next;

  logic [TIME_WIDTH-1:0]            s_time;
  logic [TIME_WIDTH-1:0]            e_time;
  logic [TAG_WIDTH-1:0]             t_tag;
  logic [sit_pkg::READ_INDEX_W-1:0] ridx;
  logic [CNT_W-1:0]                 cnt;
  logic [CNT_W-1:0]                 idx;
  logic [CNT_W-1:0]                 pos;
  logic [TIME_WIDTH-1:0]            prev_end;
  logic [TIME_WIDTH-1:0]            next_start;
  logic [sit_pkg::STATUS_W-1:0]     res_status;
  logic [CW-1:0]                    res_pos;

  logic [TIME_WIDTH-1:0]        rd_start;
  logic [TIME_WIDTH-1:0]        rd_end;
  logic [TAG_WIDTH-1:0]         rd_tag;
  logic [CW-1:0]                ridx_ext;
  logic [CW-1:0]                cnt_ext;
  logic [CNT_W-1:0]             idx_dec;
  logic                         in_range;
  logic                         found;
  logic [sit_pkg::STATUS_W-1:0] check_status;

  assign rd_start = mem_rdata[EW-1 -: TIME_WIDTH];
  assign rd_end   = mem_rdata[TAG_WIDTH+TIME_WIDTH-1 -: TIME_WIDTH];
  assign rd_tag   = mem_rdata[TAG_WIDTH-1:0];
  assign ridx_ext = CW'(ridx);
  assign cnt_ext  = CW'(cnt);
  assign idx_dec  = idx - CNT_W'(1);
  assign in_range = ridx_ext < cnt_ext;
  assign found    = !(rd_start < s_time);

  // Previous-entry overlap wins over next-entry overlap, which wins over full.
  always_comb begin
    if (pos != '0 && s_time < prev_end) begin
      check_status = sit_pkg::STATUS_PREV;
    end else if (pos != cnt && next_start < e_time) begin
      check_status = sit_pkg::STATUS_NEXT;
    end else if (cnt >= CNT_W'(CAPACITY)) begin
      check_status = sit_pkg::STATUS_FULL;
    end else begin
      check_status = sit_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sit_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = pos[AW-1:0];
    mem_wdata  = {s_time, e_time, t_tag};
    mem_raddr  = idx[AW-1:0];
    case (state)
      sit_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (opcode == sit_pkg::OP_READ) ? sit_pkg::ST_READ : sit_pkg::ST_SCAN;
        end
      end
      sit_pkg::ST_SCAN: begin
        state_next = (idx == cnt) ? sit_pkg::ST_CHECK : sit_pkg::ST_SCAN_WAIT;
      end
      sit_pkg::ST_SCAN_WAIT: begin
        state_next = found ? sit_pkg::ST_CHECK : sit_pkg::ST_SCAN;
      end
      sit_pkg::ST_CHECK: begin
        if (check_status != sit_pkg::STATUS_OK) begin
          state_next = sit_pkg::ST_DONE;
        end else if (pos == cnt) begin
          state_next = sit_pkg::ST_PLACE;
        end else begin
          state_next = sit_pkg::ST_SHIFT_RD;
        end
      end
      sit_pkg::ST_SHIFT_RD: begin
        mem_raddr  = idx_dec[AW-1:0];
        state_next = sit_pkg::ST_SHIFT_WR;
      end
      sit_pkg::ST_SHIFT_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = idx[AW-1:0];
        mem_wdata  = mem_rdata;
        state_next = (idx_dec == pos) ? sit_pkg::ST_PLACE : sit_pkg::ST_SHIFT_RD;
      end
      sit_pkg::ST_PLACE: begin
        mem_we     = 1'b1;
        state_next = sit_pkg::ST_DONE;
      end
      sit_pkg::ST_READ: begin
        mem_raddr  = ridx_ext[AW-1:0];
        state_next = in_range ? sit_pkg::ST_READ_WAIT : sit_pkg::ST_DONE;
      end
      sit_pkg::ST_READ_WAIT: begin
        state_next = sit_pkg::ST_DONE;
      end
      sit_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = sit_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sit_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == sit_pkg::ST_PLACE) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      sit_pkg::ST_IDLE: begin
        if (in_valid) begin
          s_time <= start_time;
          e_time <= end_time;
          t_tag  <= tag;
          ridx   <= read_index;
          idx    <= '0;
        end
      end
      sit_pkg::ST_SCAN: begin
        if (idx == cnt) begin
          pos <= idx;
        end
      end
      sit_pkg::ST_SCAN_WAIT: begin
        if (found) begin
          pos        <= idx;
          next_start <= rd_start;
        end else begin
          prev_end <= rd_end;
          idx      <= idx + CNT_W'(1);
        end
      end
      sit_pkg::ST_CHECK: begin
        res_status <= check_status;
        res_pos    <= CW'(pos);
        res_start  <= '0;
        res_end    <= '0;
        res_tag    <= '0;
        idx        <= cnt;
      end
      sit_pkg::ST_SHIFT_WR: begin
        idx <= idx_dec;
      end
      sit_pkg::ST_READ: begin
        res_pos    <= ridx_ext;
        res_status <= in_range ? sit_pkg::STATUS_OK : sit_pkg::STATUS_RANGE;
        res_start  <= '0;
        res_end    <= '0;
        res_tag    <= '0;
      end
      sit_pkg::ST_READ_WAIT: begin
        res_start <= rd_start;
        res_end   <= rd_end;
        res_tag   <= rd_tag;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_hdr.status   = res_status;
    res_hdr.position = res_pos[sit_pkg::POSITION_W-1:0];
    res_hdr.count    = cnt_ext[sit_pkg::COUNT_W-1:0];
  end

endmodule

FILE: rtl/sorted_interval_table_insert_unit.sv
// Sorted interval table: each word either inserts an interval with an overlap check or reads
// an entry, and every word returns one result word. All entries live in one memory with a
// single write port and a registered read port, so the sequencer visits one entry at a time:
// it sets the address in one state and uses the data in a second state. A read waits for the
// memory data only when the index is in range. An insert that lands at position p in a table
// of n entries searches the entries up to p, checks for overlap and a full table, moves the
// n - p entries from p upward up by one, and makes the final write; a rejected insert stops
// after the check. The memory needs no clearing after reset, only the entry count is cleared.
// A finished result waits in an output register, so the next word can be taken meanwhile.
module sorted_interval_table_insert_unit #(
  parameter int CAPACITY   = sit_pkg::CAPACITY_DEF,
  parameter int TIME_WIDTH = sit_pkg::TIME_WIDTH_DEF,
  parameter int TAG_WIDTH  = sit_pkg::TAG_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              opcode,
  input  logic [TIME_WIDTH-1:0]             start_time,
  input  logic [TIME_WIDTH-1:0]             end_time,
  input  logic [TAG_WIDTH-1:0]              tag,
  input  logic [sit_pkg::READ_INDEX_W-1:0]  read_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sit_pkg::STATUS_W-1:0]      status,
  output logic [sit_pkg::POSITION_W-1:0]    position,
  output logic [sit_pkg::COUNT_W-1:0]       count,
  output logic [TIME_WIDTH-1:0]             entry_start,
  output logic [TIME_WIDTH-1:0]             entry_end,
  output logic [TAG_WIDTH-1:0]              entry_tag
);

  localparam int AW = $clog2(CAPACITY);
  localparam int EW = 2 * TIME_WIDTH + TAG_WIDTH;

  logic                  res_valid;
  logic                  res_ready;
  sit_pkg::res_hdr_t     res_hdr;
  logic [TIME_WIDTH-1:0] res_start;
  logic [TIME_WIDTH-1:0] res_end;
  logic [TAG_WIDTH-1:0]  res_tag;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [EW-1:0]         mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [EW-1:0]         mem_rdata;

  sit_ctrl #(
    .CAPACITY   (CAPACITY),
    .TIME_WIDTH (TIME_WIDTH),
    .TAG_WIDTH  (TAG_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .start_time (start_time),
    .end_time   (end_time),
    .tag        (tag),
    .read_index (read_index),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_hdr    (res_hdr),
    .res_start  (res_start),
    .res_end    (res_end),
    .res_tag    (res_tag),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  sit_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status      <= res_hdr.status;
      position    <= res_hdr.position;
      count       <= res_hdr.count;
      entry_start <= res_start;
      entry_end   <= res_end;
      entry_tag   <= res_tag;
    end
  end

endmodule

FILE: rtl/sit_checker.sv
// Port-level assertions for the sorted interval table, bound to the top level.
module sit_checker #(
  parameter int TIME_WIDTH = sit_pkg::TIME_WIDTH_DEF,
  parameter int TAG_WIDTH  = sit_pkg::TAG_WIDTH_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [sit_pkg::STATUS_W-1:0]     status,
  input logic [sit_pkg::POSITION_W-1:0]   position,
  input logic [sit_pkg::COUNT_W-1:0]      count,
  input logic [TIME_WIDTH-1:0]            entry_start,
  input logic [TIME_WIDTH-1:0]            entry_end,
  input logic [TAG_WIDTH-1:0]             entry_tag
);

  localparam int CW = sit_pkg::COUNT_W;

  logic [sit_pkg::COUNT_W-1:0] last_count;
  logic                        delivered;

  assign delivered = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_count <= '0;
    end else if (delivered) begin
      last_count <= count;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({status, position, count}))
    else $error("result word changed while stalled");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    delivered |-> count == last_count || count == last_count + CW'(1))
    else $error("entry count moved by more than one between results");

  a_reject_keeps: assert property (@(posedge clk) disable iff (rst)
    delivered && status != sit_pkg::STATUS_OK |-> count == last_count)
    else $error("rejected word changed the entry count");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    delivered && status == sit_pkg::STATUS_RANGE |->
      entry_start == '0 && entry_end == '0 && entry_tag == '0)
    else $error("out-of-range read returned entry data");

endmodule

bind sorted_interval_table_insert_unit sit_checker #(
  .TIME_WIDTH (TIME_WIDTH),
  .TAG_WIDTH  (TAG_WIDTH)
) u_sit_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .position    (position),
  .count       (count),
  .entry_start (entry_start),
  .entry_end   (entry_end),
  .entry_tag   (entry_tag)
);
